/* src/llt_pkg.sv */
// Shared types and constants for the link-layer SN/NESN acknowledgement tracker.
// Holds the header field layout, the packet kinds, the class word and the outcome codes.
// No dependencies.
package llt_pkg;

	localparam logic [7:0] HDR_RSVD_MASK = 8'hE0;
	localparam logic [7:0] MAX_LEN       = 8'd60;
	localparam logic [1:0] LLID_NONE     = 2'd0;
	localparam logic [1:0] LLID_EMPTY    = 2'd1;
	localparam logic [1:0] LLID_DATA     = 2'd2;

	localparam logic [7:0] KIND_WHEEL = 8'd6;
	localparam logic [7:0] LEN_WHEEL  = 8'd10;
	localparam logic [7:0] KIND_MEDIA = 8'd2;
	localparam logic [7:0] LEN_MEDIA  = 8'd6;
	localparam logic [7:0] KIND_MIC   = 8'd3;
	localparam logic [7:0] LEN_MIC    = 8'd7;

	localparam logic [7:0] HEAD_BYTE_ONE   = 8'd0;
	localparam logic [7:0] HEAD_BYTE_TWO   = 8'd1;
	localparam logic [7:0] HEAD_BYTE_THREE = 8'd1;

	localparam logic [7:0] SENT_NONE = 8'd0;
	localparam logic [7:0] SENT_BOOT = 8'd1;

	typedef enum logic [2:0] {
		OUT_REJECT = 3'd0,
		OUT_STALE  = 3'd1,
		OUT_DUP    = 3'd2,
		OUT_DATA   = 3'd3,
		OUT_EMPTY  = 3'd4,
		OUT_BOOT   = 3'd5
	} outcome_t;

	// Everything the back end needs to know about one packet, state-independent.
	typedef struct packed {
		logic malformed;
		logic known_data;
		logic empty;
		logic boot_bad;
		logic sent_len_nz;
		logic sent_fmt_ok;   // sent header has the shape 0000_xy01
		logic sent_sn;
		logic sent_nesn;
		logic sn;
		logic nesn;
	} cls_t;

endpackage

/* src/llt_front.sv */
// Front end: accepts packets and classifies them into a cls_t word, one register stage.
// Depends on llt_pkg.
module llt_front
	import llt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_header,
	input  logic [7:0] payload_length,
	input  logic       payload_present,
	input  logic [7:0] byte_zero,
	input  logic [7:0] byte_one,
	input  logic [7:0] byte_two,
	input  logic [7:0] byte_three,
	input  logic       tail_valid,
	input  logic [7:0] sent_header,
	input  logic [7:0] tx_length,
	output logic       cls_valid,
	input  logic       cls_ready,
	output cls_t       cls
);

	logic       valid_s1;
	cls_t       cls_s1;
	cls_t       cls_d;
	logic [1:0] llid;
	logic       head_ok;
	logic       kind_ok;

	always_comb begin
		llid    = rx_header[1:0];
		head_ok = (llid == LLID_DATA) && payload_present && (byte_one == HEAD_BYTE_ONE) &&
			(byte_two == HEAD_BYTE_TWO) && (byte_three == HEAD_BYTE_THREE) && tail_valid;
		kind_ok = ((payload_length == LEN_WHEEL) && (byte_zero == KIND_WHEEL)) ||
			((payload_length == LEN_MEDIA) && (byte_zero == KIND_MEDIA)) ||
			((payload_length == LEN_MIC) && (byte_zero == KIND_MIC));

		cls_d.malformed   = ((rx_header & HDR_RSVD_MASK) != 8'd0) || (llid == LLID_NONE) ||
			(payload_length > MAX_LEN) || ((payload_length != 8'd0) && !payload_present);
		cls_d.known_data  = head_ok && kind_ok;
		cls_d.empty       = (llid == LLID_EMPTY) && (payload_length == 8'd0);
		cls_d.sent_len_nz = (tx_length != 8'd0);
		cls_d.sent_fmt_ok = (sent_header[7:4] == 4'd0) && (sent_header[1:0] == 2'b01);
		cls_d.sent_sn     = sent_header[3];
		cls_d.sent_nesn   = sent_header[2];
		cls_d.sn          = rx_header[3];
		cls_d.nesn        = rx_header[2];
		// bootstrap refusal depends only on the packet itself
		cls_d.boot_bad    = !(cls_d.known_data || cls_d.empty) ||
			(cls_d.empty && (sent_header != SENT_BOOT)) || cls_d.sent_len_nz ||
			((sent_header != SENT_NONE) && (sent_header != SENT_BOOT)) ||
			((sent_header == SENT_BOOT) && !rx_header[2]);
	end

	assign in_ready  = !valid_s1 || cls_ready;
	assign cls_valid = valid_s1;
	assign cls       = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cls_s1 <= cls_d;
		end
	end

endmodule

/* src/llt_queue.sv */
// Two-entry queue of class words between the front and back ends.
// Depends on llt_pkg.
module llt_queue
	import llt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cls_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output cls_t rd_data
);

	cls_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* src/llt_back.sv */
// Back end: link state, sequence bits, event counters and the result register.
// Depends on llt_pkg.
module llt_back
	import llt_pkg::*;
#(
	parameter int COUNTER_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cls_valid,
	output logic        cls_ready,
	input  cls_t        cls,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic [2:0]  outcome,
	output logic        acked_now,
	output logic [7:0]  next_header,
	output logic [31:0] rejected_total,
	output logic [31:0] empty_total,
	output logic [31:0] data_total,
	output logic [31:0] stale_total,
	output logic [31:0] ack_total,
	output logic [31:0] duplicate_total
);

	logic                     active_q, tx_seq_q, rx_next_q;
	logic [COUNTER_WIDTH-1:0] rej_cnt_q, empty_cnt_q, data_cnt_q;
	logic [COUNTER_WIDTH-1:0] stale_cnt_q, ack_cnt_q, dup_cnt_q;
	logic                     valid_q, acc_q, acked_q;
	outcome_t                 outcome_q;

	logic     active_d, tx_seq_d, rx_next_d;
	logic     inc_rej, inc_empty, inc_data, inc_stale, inc_ack, inc_dup;
	logic     acc_d, acked_d;
	outcome_t outcome_d;
	logic     pop;

	assign cls_ready = !valid_q || out_ready;
	assign pop       = cls_valid && cls_ready;

	always_comb begin
		active_d  = active_q;
		tx_seq_d  = tx_seq_q;
		rx_next_d = rx_next_q;
		inc_rej   = 1'b0;
		inc_empty = 1'b0;
		inc_data  = 1'b0;
		inc_stale = 1'b0;
		inc_ack   = 1'b0;
		inc_dup   = 1'b0;
		acc_d     = 1'b0;
		acked_d   = 1'b0;
		outcome_d = OUT_REJECT;
		priority if (cls.malformed) begin
			inc_rej = 1'b1;
		end else if (!active_q) begin
			if (cls.boot_bad) begin
				inc_rej = 1'b1;
			end else begin
				active_d  = 1'b1;
				tx_seq_d  = cls.nesn;
				rx_next_d = !cls.sn;
				inc_empty = cls.empty;
				inc_data  = !cls.empty;
				acc_d     = 1'b1;
				outcome_d = OUT_BOOT;
			end
		end else if (cls.sent_len_nz || !cls.sent_fmt_ok || (cls.sent_sn != tx_seq_q) ||
			(cls.sent_nesn != rx_next_q)) begin
			inc_stale = 1'b1;
			outcome_d = OUT_STALE;
		end else begin
			if (cls.nesn != tx_seq_q) begin
				tx_seq_d = !tx_seq_q;
				inc_ack  = 1'b1;
				acked_d  = 1'b1;
			end
			priority if (cls.sn != rx_next_q) begin
				inc_dup   = 1'b1;
				acc_d     = 1'b1;
				outcome_d = OUT_DUP;
			end else if (!cls.empty && !cls.known_data) begin
				inc_rej = 1'b1;
			end else begin
				rx_next_d = !rx_next_q;
				inc_data  = cls.known_data;
				inc_empty = !cls.known_data;
				acc_d     = 1'b1;
				outcome_d = cls.known_data ? OUT_DATA : OUT_EMPTY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			tx_seq_q    <= 1'b0;
			rx_next_q   <= 1'b0;
			rej_cnt_q   <= '0;
			empty_cnt_q <= '0;
			data_cnt_q  <= '0;
			stale_cnt_q <= '0;
			ack_cnt_q   <= '0;
			dup_cnt_q   <= '0;
			valid_q     <= 1'b0;
			acc_q       <= 1'b0;
			acked_q     <= 1'b0;
			outcome_q   <= OUT_REJECT;
		end else if (cls_ready) begin
			valid_q <= cls_valid;
			if (pop) begin
				active_q    <= active_d;
				tx_seq_q    <= tx_seq_d;
				rx_next_q   <= rx_next_d;
				rej_cnt_q   <= rej_cnt_q + COUNTER_WIDTH'(inc_rej);
				empty_cnt_q <= empty_cnt_q + COUNTER_WIDTH'(inc_empty);
				data_cnt_q  <= data_cnt_q + COUNTER_WIDTH'(inc_data);
				stale_cnt_q <= stale_cnt_q + COUNTER_WIDTH'(inc_stale);
				ack_cnt_q   <= ack_cnt_q + COUNTER_WIDTH'(inc_ack);
				dup_cnt_q   <= dup_cnt_q + COUNTER_WIDTH'(inc_dup);
				acc_q       <= acc_d;
				acked_q     <= acked_d;
				outcome_q   <= outcome_d;
			end
		end
	end

	// state only moves on a pop, and a pop reloads the result, so the state
	// registers are themselves the held result
	assign out_valid       = valid_q;
	assign accepted        = acc_q;
	assign outcome         = outcome_q;
	assign acked_now       = acked_q;
	assign next_header     = active_q ? {4'd0, tx_seq_q, rx_next_q, 2'b01} : 8'd0;
	assign rejected_total  = 32'(rej_cnt_q);
	assign empty_total     = 32'(empty_cnt_q);
	assign data_total      = 32'(data_cnt_q);
	assign stale_total     = 32'(stale_cnt_q);
	assign ack_total       = 32'(ack_cnt_q);
	assign duplicate_total = 32'(dup_cnt_q);

endmodule

/* src/link_layer_sn_nesn_ack_tracker.sv */
// Top level of the link-layer SN/NESN acknowledgement tracker.
// Instantiates llt_front, llt_queue and llt_back; depends on llt_pkg.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   in      | in_valid / in_ready  | rx_header .. tx_length, one received packet
//   out     | out_valid/ out_ready | accepted, outcome, acked_now, next_header,
//           |                      | six 32-bit event totals
//
// One packet per cycle sustained while out is not stalled; each item passes
// the classify register, the queue and the result register from input accept
// to result valid. The link state and counters are updated in the back end, which
// sets the rate. Reset (arst_n low) clears the link state, counters and queue.
// A stall on out holds the result and fills the queue; in_ready drops only once
// the classify stage and both queue entries are occupied.
module link_layer_sn_nesn_ack_tracker
	import llt_pkg::*;
#(
	parameter int COUNTER_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_header,
	input  logic [7:0]  payload_length,
	input  logic        payload_present,
	input  logic [7:0]  byte_zero,
	input  logic [7:0]  byte_one,
	input  logic [7:0]  byte_two,
	input  logic [7:0]  byte_three,
	input  logic        tail_valid,
	input  logic [7:0]  sent_header,
	input  logic [7:0]  tx_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic [2:0]  outcome,
	output logic        acked_now,
	output logic [7:0]  next_header,
	output logic [31:0] rejected_total,
	output logic [31:0] empty_total,
	output logic [31:0] data_total,
	output logic [31:0] stale_total,
	output logic [31:0] ack_total,
	output logic [31:0] duplicate_total
);

	// front -> queue
	logic fq_valid, fq_ready;
	cls_t fq_cls;
	// queue -> back
	logic qb_valid, qb_ready;
	cls_t qb_cls;

	// Front end: header/length sanity, packet kind and sent-header shape.
	// Nothing here depends on link state, so it never waits on the back end
	// except through the queue.
	llt_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_header       (rx_header),
		.payload_length  (payload_length),
		.payload_present (payload_present),
		.byte_zero       (byte_zero),
		.byte_one        (byte_one),
		.byte_two        (byte_two),
		.byte_three      (byte_three),
		.tail_valid      (tail_valid),
		.sent_header     (sent_header),
		.tx_length       (tx_length),
		.cls_valid       (fq_valid),
		.cls_ready       (fq_ready),
		.cls             (fq_cls)
	);

	// Two entries absorb the ready turnaround between the two halves.
	llt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_data  (fq_cls),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_data  (qb_cls)
	);

	// Back end: bootstrap, staleness, ack (NESN), duplicate (SN), counters.
	llt_back #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cls_valid       (qb_valid),
		.cls_ready       (qb_ready),
		.cls             (qb_cls),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.accepted        (accepted),
		.outcome         (outcome),
		.acked_now       (acked_now),
		.next_header     (next_header),
		.rejected_total  (rejected_total),
		.empty_total     (empty_total),
		.data_total      (data_total),
		.stale_total     (stale_total),
		.ack_total       (ack_total),
		.duplicate_total (duplicate_total)
	);

endmodule
